FILE: rtl/fcpa_pkg.sv
// shared types, codes and sizes for the fixed chunk pool allocator
package fcpa_pkg;

  // field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CHUNK_W  = 17;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // default pool depth
  localparam int unsigned MAX_CHUNKS_DEF = 256;

  // smallest chunk size, one pointer
  localparam logic [CHUNK_W-1:0] MIN_CHUNK = CHUNK_W'(4);

  // iterative divider, one quotient bit per step
  localparam int unsigned DIV_STEPS = ADDR_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = 2'd2;

  // source of the result address
  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_FRESH = 2'd1,
    SRC_STACK = 2'd2
  } res_src_e;

  // controller to datapath
  typedef struct packed {
    logic                latch_item;
    logic                cfg_wr;
    logic                pop;
    logic                push;
    logic                take_fresh;
    logic                div_start;
    logic                div_cfg;
    logic                reinit;
    logic                res_load;
    res_src_e            res_src;
    logic [STATUS_W-1:0] res_status;
  } fcpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              stack_empty;
    logic              stack_full;
    logic              fresh_none;
    logic              addr_zero;
    logic              out_of_range;
    logic              cfg_known;
    logic              div_done;
    logic              rem_zero;
  } fcpa_stat_t;

endpackage

FILE: rtl/fcpa_div.sv
// restoring divider, one quotient bit per cycle
module fcpa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fcpa_pkg::ADDR_W-1:0]   dividend_i,
  input  logic [fcpa_pkg::CHUNK_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [fcpa_pkg::ADDR_W-1:0]   quotient_o,
  output logic [fcpa_pkg::CHUNK_W-1:0]  remainder_o
);

  localparam int unsigned AW = fcpa_pkg::ADDR_W;
  localparam int unsigned CW = fcpa_pkg::CHUNK_W;
  localparam int unsigned NW = fcpa_pkg::DIV_CNT_W;

  logic          running_q, running_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] quo_q, quo_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dvs_q, dvs_d;
  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          fits;

  // one trial subtraction
  assign trial = {rem_q, quo_q[AW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  // step control
  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = '0;
      quo_d     = dividend_i;
      rem_d     = '0;
      dvs_d     = divisor_i;
    end else if (running_q) begin
      quo_d = {quo_q[AW-2:0], fits};
      rem_d = fits ? diff[CW-1:0] : trial[CW-1:0];
      cnt_d = cnt_q + NW'(1);
      if (cnt_q == NW'(fcpa_pkg::DIV_STEPS - 1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: rtl/fcpa_dp.sv
// datapath: config registers, freed stack, fresh pointer, divider and result register
module fcpa_dp #(
  parameter int unsigned MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fcpa_pkg::fcpa_cmd_t             cmd_i,
  output fcpa_pkg::fcpa_stat_t            stat_o,
  input  logic [fcpa_pkg::MODE_W-1:0]     mode_i,
  input  logic [fcpa_pkg::ADDR_W-1:0]     address_i,
  input  logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fcpa_pkg::ADDR_W-1:0]     cfg_data_i,
  output logic                            result_valid_o,
  output logic [fcpa_pkg::ADDR_W-1:0]     chunk_address_o,
  output logic [fcpa_pkg::STATUS_W-1:0]   status_o
);

  localparam int unsigned AW  = fcpa_pkg::ADDR_W;
  localparam int unsigned CKW = fcpa_pkg::CHUNK_W;
  localparam int unsigned NW  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned IW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam logic [NW-1:0] MaxCount = NW'(MAX_CHUNKS);
  localparam logic [AW-1:0] MaxWide  = AW'(MAX_CHUNKS);

  // configuration
  logic [AW-1:0]  base_q, base_d;
  logic [AW-1:0]  bytes_q, bytes_d;
  logic [CKW-1:0] chunk_q, chunk_d;
  logic [CKW-1:0] eff_chunk;

  // pool state
  logic [NW-1:0] count_q, count_d;
  logic [AW-1:0] fresh_addr_q, fresh_addr_d;
  logic [NW-1:0] fresh_left_q, fresh_left_d;

  // latched item
  logic [fcpa_pkg::MODE_W-1:0] mode_q;
  logic [AW-1:0]               addr_q;

  // freed stack memory
  logic [AW-1:0] stack_mem [MAX_CHUNKS];
  logic [AW-1:0] stack_rd_q;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [NW-1:0] count_dec;

  // result register
  logic                          res_valid_q;
  logic [AW-1:0]                 res_addr_q, res_addr_d;
  logic [fcpa_pkg::STATUS_W-1:0] res_status_q;

  // divider
  logic [AW-1:0]  div_dividend;
  logic [AW-1:0]  div_quo;
  logic [CKW-1:0] div_rem;
  logic           div_done;
  logic [AW:0]    region_end;

  assign eff_chunk  = (chunk_q < fcpa_pkg::MIN_CHUNK) ? fcpa_pkg::MIN_CHUNK : chunk_q;
  assign count_dec  = count_q - NW'(1);
  assign wr_idx     = count_q[IW-1:0];
  assign rd_idx     = count_dec[IW-1:0];
  assign region_end = {1'b0, base_q} + {1'b0, bytes_q};

  // shared divider: chunk count on reinit, alignment on query
  assign div_dividend = cmd_i.div_cfg ? bytes_q : (addr_q - base_q);

  fcpa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (eff_chunk),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // status to controller
  always_comb begin
    stat_o.mode         = mode_q;
    stat_o.stack_empty  = count_q == '0;
    stat_o.stack_full   = count_q == MaxCount;
    stat_o.fresh_none   = fresh_left_q == '0;
    stat_o.addr_zero    = addr_q == '0;
    stat_o.out_of_range = (addr_q < base_q) || ({1'b0, addr_q} >= region_end);
    stat_o.cfg_known    = (cfg_index_i == fcpa_pkg::CFG_REGION_BASE) ||
                          (cfg_index_i == fcpa_pkg::CFG_REGION_BYTES) ||
                          (cfg_index_i == fcpa_pkg::CFG_CHUNK_BYTES);
    stat_o.div_done     = div_done;
    stat_o.rem_zero     = div_rem == '0;
  end

  // config register writes
  always_comb begin
    base_d  = base_q;
    bytes_d = bytes_q;
    chunk_d = chunk_q;
    if (cmd_i.cfg_wr) begin
      case (cfg_index_i)
        fcpa_pkg::CFG_REGION_BASE:  base_d  = cfg_data_i;
        fcpa_pkg::CFG_REGION_BYTES: bytes_d = cfg_data_i;
        fcpa_pkg::CFG_CHUNK_BYTES:  chunk_d = cfg_data_i[CKW-1:0];
        default: ;
      endcase
    end
  end

  // pool state updates
  always_comb begin
    count_d      = count_q;
    fresh_addr_d = fresh_addr_q;
    fresh_left_d = fresh_left_q;
    if (cmd_i.reinit) begin
      count_d      = '0;
      fresh_addr_d = base_q;
      fresh_left_d = (div_quo > MaxWide) ? MaxCount : div_quo[NW-1:0];
    end else if (cmd_i.pop) begin
      count_d = count_dec;
    end else if (cmd_i.push) begin
      count_d = count_q + NW'(1);
    end else if (cmd_i.take_fresh) begin
      fresh_addr_d = fresh_addr_q + {{(AW - CKW){1'b0}}, eff_chunk};
      fresh_left_d = fresh_left_q - NW'(1);
    end
  end

  // result address select
  always_comb begin
    case (cmd_i.res_src)
      fcpa_pkg::SRC_FRESH: res_addr_d = fresh_addr_q;
      fcpa_pkg::SRC_STACK: res_addr_d = stack_rd_q;
      default:             res_addr_d = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      bytes_q      <= '0;
      chunk_q      <= fcpa_pkg::MIN_CHUNK;
      count_q      <= '0;
      fresh_addr_q <= '0;
      fresh_left_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      base_q       <= base_d;
      bytes_q      <= bytes_d;
      chunk_q      <= chunk_d;
      count_q      <= count_d;
      fresh_addr_q <= fresh_addr_d;
      fresh_left_q <= fresh_left_d;
      res_valid_q  <= cmd_i.res_load;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      mode_q <= mode_i;
      addr_q <= address_i;
    end
    if (cmd_i.res_load) begin
      res_addr_q   <= res_addr_d;
      res_status_q <= cmd_i.res_status;
    end
  end

  // freed stack, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[wr_idx] <= addr_q;
    end
    if (cmd_i.pop) begin
      stack_rd_q <= stack_mem[rd_idx];
    end
  end

  assign result_valid_o  = res_valid_q;
  assign chunk_address_o = res_addr_q;
  assign status_o        = res_status_q;

endmodule

FILE: rtl/fcpa_ctrl.sv
// controller: sequences each item and each reinit over the datapath
module fcpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  fcpa_pkg::fcpa_stat_t  stat_i,
  output fcpa_pkg::fcpa_cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_POP   = 6'b000100,
    S_CFGLD = 6'b001000,
    S_DIVQ  = 6'b010000,
    S_DIVC  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = (state_q == S_IDLE) && !start;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch_item = 1'b1;
          state_d          = S_EXEC;
        end else if (cfg_valid_i) begin
          cmd_o.cfg_wr = 1'b1;
          if (stat_i.cfg_known) begin
            state_d = S_CFGLD;
          end
        end
      end
      S_EXEC: begin
        state_d          = S_IDLE;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_src    = fcpa_pkg::SRC_ZERO;
        cmd_o.res_status = fcpa_pkg::ST_OK;
        case (stat_i.mode)
          fcpa_pkg::MODE_ALLOC: begin
            if (!stat_i.stack_empty) begin
              // pop: wait for the stack read
              cmd_o.res_load = 1'b0;
              cmd_o.pop      = 1'b1;
              state_d        = S_POP;
            end else if (!stat_i.fresh_none) begin
              cmd_o.take_fresh = 1'b1;
              cmd_o.res_src    = fcpa_pkg::SRC_FRESH;
            end else begin
              cmd_o.res_status = fcpa_pkg::ST_EXHAUSTED;
            end
          end
          fcpa_pkg::MODE_FREE: begin
            // null or overflow frees are dropped
            cmd_o.push = !stat_i.addr_zero && !stat_i.stack_full;
          end
          fcpa_pkg::MODE_QUERY: begin
            if (stat_i.out_of_range) begin
              cmd_o.res_status = fcpa_pkg::ST_RANGE;
            end else begin
              cmd_o.res_load  = 1'b0;
              cmd_o.div_start = 1'b1;
              state_d         = S_DIVQ;
            end
          end
          default: ;
        endcase
      end
      S_POP: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_src    = fcpa_pkg::SRC_STACK;
        cmd_o.res_status = fcpa_pkg::ST_OK;
        state_d          = S_IDLE;
      end
      S_CFGLD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_cfg   = 1'b1;
        state_d         = S_DIVC;
      end
      S_DIVQ: begin
        if (stat_i.div_done) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_src    = fcpa_pkg::SRC_ZERO;
          cmd_o.res_status = stat_i.rem_zero ? fcpa_pkg::ST_OK : fcpa_pkg::ST_RANGE;
          state_d          = S_IDLE;
        end
      end
      S_DIVC: begin
        cmd_o.div_cfg = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.reinit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/fixed_chunk_pool_allocator_unit.sv
// top level of the fixed chunk pool allocator
//
//   channel   direction  handshake                 payload
//   request   in         start / busy              mode_i, address_i
//   result    out        result_valid_o strobe     chunk_address_o, status_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// allocate (fresh or exhausted), free, mode 3 and a query outside the region pass
// through the execute state only before the next accept; allocate from the freed stack
// also passes the pop state, for the memory read.
// a query inside the region starts the shared divider, runs its 32 steps, sees done
// and then loads the result.
// a write to a known config register keeps busy high while the
// same divider recomputes the chunk count; after reset the pool is empty and ready.
// results are shown for one cycle and cannot be stalled.
module fixed_chunk_pool_allocator_unit #(
  parameter int unsigned MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [fcpa_pkg::MODE_W-1:0]     mode_i,
  input  logic [fcpa_pkg::ADDR_W-1:0]     address_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fcpa_pkg::ADDR_W-1:0]     cfg_data_i,
  output logic                            result_valid_o,
  output logic [fcpa_pkg::ADDR_W-1:0]     chunk_address_o,
  output logic [fcpa_pkg::STATUS_W-1:0]   status_o
);

  fcpa_pkg::fcpa_cmd_t  cmd;
  fcpa_pkg::fcpa_stat_t stat;

  // sequencer
  fcpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  fcpa_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (mode_i),
    .address_i       (address_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .chunk_address_o (chunk_address_o),
    .status_o        (status_o)
  );

endmodule

FILE: rtl/fcpa_chk.sv
// port-level checks for the fixed chunk pool allocator, bound to the top level
module fcpa_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          cfg_ready_o,
  input logic                          result_valid_o,
  input logic [fcpa_pkg::ADDR_W-1:0]   chunk_address_o,
  input logic [fcpa_pkg::STATUS_W-1:0] status_o
);

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // config is only taken while no item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy)
    else $error("config ready while busy");

  // one item at a time: strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes in consecutive cycles");

  // a failed request never carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != fcpa_pkg::ST_OK) |-> chunk_address_o == '0)
    else $error("address given with failing status");

  // status is a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == fcpa_pkg::ST_OK) ||
                       (status_o == fcpa_pkg::ST_EXHAUSTED) ||
                       (status_o == fcpa_pkg::ST_RANGE))
    else $error("undefined status code");

endmodule

bind fixed_chunk_pool_allocator_unit fcpa_chk u_fcpa_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .cfg_ready_o     (cfg_ready_o),
  .result_valid_o  (result_valid_o),
  .chunk_address_o (chunk_address_o),
  .status_o        (status_o)
);

FILE: verif/fixed_chunk_pool_allocator_unit_tb.sv
// testbench for the fixed chunk pool allocator: directed table, then random pool traffic
module fixed_chunk_pool_allocator_unit_tb;
  import fcpa_pkg::*;

  localparam int unsigned POOL_DEPTH = MAX_CHUNKS_DEF;
  localparam int RAND_ITEMS = 2000;
  localparam int QUIET_ITEMS = 250;
  localparam int TAIL_CYCLES = 40;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
  } pool_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // one directed row: an item or a register write, with an optional fixed answer
  typedef struct packed {
    row_kind_e           kind;
    logic [1:0]          sel;
    logic [ADDR_W-1:0]   value;
    logic                known;
    logic [ADDR_W-1:0]   want_addr;
    logic [STATUS_W-1:0] want_status;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [MODE_W-1:0]    mode_i = '0;
  logic [ADDR_W-1:0]    address_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_W-1:0]    cfg_data_i = '0;
  logic                 result_valid_o;
  logic [ADDR_W-1:0]    chunk_address_o;
  logic [STATUS_W-1:0]  status_o;

  // pool state as the testbench sees it
  logic [ADDR_W-1:0]  pool_base;
  logic [ADDR_W-1:0]  pool_bytes;
  logic [CHUNK_W-1:0] pool_chunk;
  logic [ADDR_W-1:0]  free_stack [POOL_DEPTH];
  int                 free_cnt;
  logic [ADDR_W-1:0]  next_fresh;
  int                 fresh_cnt;

  pool_res_t          pending_q [$];
  logic [ADDR_W-1:0]  held_q [$];
  pool_res_t          oldest;
  int                 fault_cnt = 0;
  logic               idle_on = 1'b1;

  stim_row_t dir_rows [37] = '{
    // empty pool after reset
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EXHAUSTED},
    '{ROW_ITEM, MODE_QUERY, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE},
    '{ROW_ITEM, MODE_NONE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EXHAUSTED},
    // unvalidated frees come back last in, first out
    '{ROW_ITEM, MODE_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_FREE,  32'h0000_0004, 1'b1, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0004, ST_OK},
    '{ROW_ITEM, MODE_FREE,  32'h0000_0008, 1'b1, 32'h0000_0000, ST_OK},
    // unknown register index must not reinit the pool
    '{ROW_CFG,  CFG_NONE,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0008, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
    // region at the top of memory, chunk size zero used as the minimum
    '{ROW_CFG,  CFG_REGION_BASE,  32'hFFFF_FFF0, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_CFG,  CFG_REGION_BYTES, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_CFG,  CFG_CHUNK_BYTES,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'hFFFF_FFF0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    // fresh address wraps to zero
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_QUERY, 32'hFFFF_FFF0, 1'b1, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_QUERY, 32'hFFFF_FFF2, 1'b1, 32'h0000_0000, ST_RANGE},
    '{ROW_ITEM, MODE_QUERY, 32'h0000_0004, 1'b1, 32'h0000_0000, ST_RANGE},
    // wide chunk, partial tail is never handed out
    '{ROW_CFG,  CFG_REGION_BASE,  32'h1000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_CFG,  CFG_REGION_BYTES, 32'h0002_FFFF, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_CFG,  CFG_CHUNK_BYTES,  32'h0001_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h1000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EXHAUSTED},
    '{ROW_ITEM, MODE_QUERY, 32'h1002_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_QUERY, 32'h1001_FFFC, 1'b0, 32'h0000_0000, ST_OK},
    // chunk size below the minimum
    '{ROW_CFG,  CFG_REGION_BASE,  32'h0000_0100, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_CFG,  CFG_REGION_BYTES, 32'h0000_0010, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_CFG,  CFG_CHUNK_BYTES,  32'h0000_0003, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0100, ST_OK},
    '{ROW_ITEM, MODE_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{ROW_ITEM, MODE_QUERY, 32'h0000_0110, 1'b1, 32'h0000_0000, ST_RANGE}
  };

  fixed_chunk_pool_allocator_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .address_i       (address_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .chunk_address_o (chunk_address_o),
    .status_o        (status_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // chunk size in use, never below one pointer
  function automatic logic [ADDR_W-1:0] chunk_size();
    return (pool_chunk < MIN_CHUNK) ? ADDR_W'(MIN_CHUNK) : ADDR_W'(pool_chunk);
  endfunction

  // empty stack, fresh chunks restart at the base
  function automatic void pool_reinit();
    logic [ADDR_W-1:0] n;
    n = pool_bytes / chunk_size();
    free_cnt = 0;
    next_fresh = pool_base;
    fresh_cnt = (n > POOL_DEPTH) ? POOL_DEPTH : int'(n);
  endfunction

  function automatic void pool_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [ADDR_W-1:0] data);
    case (idx)
      CFG_REGION_BASE:  pool_base = data;
      CFG_REGION_BYTES: pool_bytes = data;
      CFG_CHUNK_BYTES:  pool_chunk = data[CHUNK_W-1:0];
      default: return;
    endcase
    pool_reinit();
  endfunction

  // one request against the pool, returns the result it gives
  function automatic pool_res_t pool_step(input logic [MODE_W-1:0] m,
                                          input logic [ADDR_W-1:0] a);
    pool_res_t r;
    logic [ADDR_W:0] top;
    r = '0;
    r.status = ST_OK;
    top = {1'b0, pool_base} + {1'b0, pool_bytes};
    case (m)
      MODE_ALLOC: begin
        if (free_cnt > 0) begin
          free_cnt--;
          r.addr = free_stack[free_cnt];
        end else if (fresh_cnt > 0) begin
          r.addr = next_fresh;
          next_fresh = next_fresh + chunk_size();
          fresh_cnt--;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      MODE_FREE: begin
        if (a != '0 && free_cnt < POOL_DEPTH) begin
          free_stack[free_cnt] = a;
          free_cnt++;
        end
      end
      MODE_QUERY: begin
        if (a < pool_base || {1'b0, a} >= top)
          r.status = ST_RANGE;
        else if (((a - pool_base) % chunk_size()) != '0)
          r.status = ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  // stop issuing and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // register write, only once the pool is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    pool_write_reg(idx, data);
  endtask

  // issue one item, predict it once accepted
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
                           input logic fixed_want, input pool_res_t want);
    pool_res_t got;
    cfg_valid_i <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= m;
    address_i <= a;
    do @(posedge clk_i); while (busy !== 1'b0);
    got = pool_step(m, a);
    pending_q.push_back(fixed_want ? want : got);
    if (m == MODE_ALLOC && got.status == ST_OK) held_q.push_back(got.addr);
  endtask

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_q.size() == 0) begin
        fault_cnt++;
        $display("%0t: result with nothing expected, got addr %h status %0d",
                 $time, chunk_address_o, status_o);
      end else begin
        oldest = pending_q.pop_front();
        if (chunk_address_o !== oldest.addr) begin
          fault_cnt++;
          $display("%0t: chunk_address mismatch, expected %h, got %h",
                   $time, oldest.addr, chunk_address_o);
        end
        if (status_o !== oldest.status) begin
          fault_cnt++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, oldest.status, status_o);
        end
      end
    end
  end

  // stimulus
  initial begin
    int                   item_cnt;
    int                   span;
    int                   pick;
    int                   j;
    int                   rot;
    logic                 fill;
    logic [MODE_W-1:0]    m;
    logic [ADDR_W-1:0]    a;
    logic [CFG_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    data;
    logic [CHUNK_W-1:0]   reg_chunk;
    logic [ADDR_W-1:0]    reg_base;
    logic [ADDR_W-1:0]    reg_bytes;
    logic [ADDR_W-1:0]    cs;

    pool_base = '0;
    pool_bytes = '0;
    pool_chunk = MIN_CHUNK;
    pool_reinit();
    item_cnt = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].sel, dir_rows[i].value);
      else
        send_item(dir_rows[i].sel, dir_rows[i].value, dir_rows[i].known,
                  '{dir_rows[i].want_addr, dir_rows[i].want_status});
    end

    // random phases, each under a fresh setting
    while (item_cnt < RAND_ITEMS) begin
      idle_on = (item_cnt < RAND_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);

      case ($urandom_range(0, 9))
        0: reg_chunk = CHUNK_W'($urandom_range(0, 3));
        1: reg_chunk = 17'h1_0000;
        2: reg_chunk = 17'h1_FFFF;
        3: reg_chunk = CHUNK_W'($urandom);
        default: reg_chunk = CHUNK_W'($urandom_range(4, 64));
      endcase
      cs = (reg_chunk < MIN_CHUNK) ? ADDR_W'(MIN_CHUNK) : ADDR_W'(reg_chunk);
      case ($urandom_range(0, 7))
        0: reg_base = '0;
        1: reg_base = 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 255));
        2: reg_base = $urandom;
        default: reg_base = $urandom & 32'hFFFF_FF00;
      endcase
      case ($urandom_range(0, 7))
        0: reg_bytes = '0;
        1: reg_bytes = 32'hFFFF_FFFF;
        2: reg_bytes = $urandom;
        default: reg_bytes = cs * ADDR_W'($urandom_range(0, 20))
                             + ADDR_W'($urandom_range(0, cs - 1));
      endcase

      // all registers, in a rotating order, sometimes an unknown index too
      if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, $urandom);
      rot = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        idx = CFG_IDX_W'((rot + k) % 3);
        case (idx)
          CFG_REGION_BASE:  data = reg_base;
          CFG_REGION_BYTES: data = reg_bytes;
          default:          data = ADDR_W'(reg_chunk);
        endcase
        write_reg(idx, data);
      end
      held_q.delete();

      // a fill phase overflows the freed stack before allocating
      fill = ($urandom_range(0, 7) == 0);
      span = fill ? 300 : $urandom_range(40, 160);
      for (int i = 0; i < span; i++) begin
        pick = $urandom_range(0, 99);
        if (fill && i < 270) begin
          m = MODE_FREE;
          a = $urandom;
        end else if (pick < 40) begin
          m = MODE_ALLOC;
          a = $urandom;
        end else if (pick < 68) begin
          m = MODE_FREE;
          if (held_q.size() != 0 && $urandom_range(0, 3) != 0) begin
            j = $urandom_range(0, held_q.size() - 1);
            a = held_q[j];
            // keep it now and then for a double free
            if ($urandom_range(0, 7) != 0) held_q.delete(j);
          end else begin
            a = $urandom;
          end
        end else if (pick < 92) begin
          m = MODE_QUERY;
          case ($urandom_range(0, 4))
            0: a = pool_base + chunk_size() * ADDR_W'($urandom_range(0, 24));
            1: a = pool_base + chunk_size() * ADDR_W'($urandom_range(0, 24))
                   + ADDR_W'($urandom_range(1, 3));
            2: a = pool_base - ADDR_W'($urandom_range(1, 4));
            3: a = pool_base + pool_bytes - ADDR_W'($urandom_range(0, 4));
            default: a = $urandom;
          endcase
        end else begin
          // ignored items: unused mode or null free
          m = ($urandom_range(0, 1) != 0) ? MODE_NONE : MODE_FREE;
          a = (m == MODE_FREE) ? '0 : $urandom;
        end
        send_item(m, a, 1'b0, '0);
        if (!(m == MODE_NONE || (m == MODE_FREE && a == '0))) item_cnt++;
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
